FILE: sv/lcg_rr_pkg.sv
`default_nettype none

package lcg_rr_pkg;

  // ansi c linear congruential constants
  localparam logic [31:0] LCG_MUL    = 32'd1103515245;
  localparam logic [31:0] LCG_ADD    = 32'd12345;
  localparam int          DRAW_SHIFT = 16;
  localparam int          RANGE_W    = 16;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;   // capture bounds, start state multiply
    logic add;        // finish state update
    logic setup;      // extract draw, span, error flag
    logic step;       // one restoring remainder step
    logic load_out;   // move result into output register
  } lcg_rr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;   // remainder step on the last draw bit
  } lcg_rr_sts_t;

endpackage

`default_nettype wire

FILE: sv/lcg_rr_ctrl.sv
`default_nettype none

module lcg_rr_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output lcg_rr_pkg::lcg_rr_cmd_t      cmd,
  input  wire lcg_rr_pkg::lcg_rr_sts_t sts
);
  import lcg_rr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SETUP,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  always_comb begin
    cmd          = '0;
    cmd.load_req = in_valid && in_ready;
    cmd.add      = (state == S_ADD);
    cmd.setup    = (state == S_SETUP);
    cmd.step     = (state == S_DIV);
    cmd.load_out = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_ADD;
          end
        end
        S_ADD:   state <= S_SETUP;
        S_SETUP: state <= S_DIV;
        S_DIV: begin
          if (sts.div_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/lcg_rr_dp.sv
`default_nettype none

module lcg_rr_dp #(
  parameter int OUT_BITS = 15
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire lcg_rr_pkg::lcg_rr_cmd_t cmd,
  output lcg_rr_pkg::lcg_rr_sts_t      sts,
  input  wire logic                    cfg_we,
  input  wire logic [31:0]             seed,
  input  wire logic [15:0]             range_low,
  input  wire logic [15:0]             range_high,
  output logic [15:0]                  value,
  output logic                         range_error
);
  import lcg_rr_pkg::*;

  localparam int IDX_W = (OUT_BITS > 1) ? $clog2(OUT_BITS) : 1;

  logic [31:0]          gen_state;
  logic [31:0]          prod;
  logic [RANGE_W-1:0]   lo;
  logic [RANGE_W-1:0]   hi;
  logic [OUT_BITS-1:0]  draw;
  logic [RANGE_W:0]     span;
  logic                 err;
  logic [RANGE_W-1:0]   rem;
  logic [IDX_W-1:0]     cnt;

  logic [RANGE_W:0]     rem_shift;
  logic [RANGE_W-1:0]   rem_next;

  // restoring remainder step, msb of the draw first
  assign rem_shift = {rem, draw[cnt]};
  assign rem_next  = (rem_shift >= span) ? RANGE_W'(rem_shift - span)
                                         : rem_shift[RANGE_W-1:0];

  assign sts.div_last = (cnt == '0);

  // generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= '0;
    end else if (cfg_we) begin
      gen_state <= seed;
    end else if (cmd.add) begin
      gen_state <= prod + LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      lo   <= range_low;
      hi   <= range_high;
      prod <= gen_state * LCG_MUL;
    end
    if (cmd.setup) begin
      draw <= gen_state[DRAW_SHIFT +: OUT_BITS];
      span <= {1'b0, hi} - {1'b0, lo} + (RANGE_W+1)'(1);
      err  <= (lo > hi);
      rem  <= '0;
      cnt  <= IDX_W'(OUT_BITS - 1);
    end
    if (cmd.step) begin
      rem <= rem_next;
      cnt <= cnt - IDX_W'(1);
    end
    if (cmd.load_out) begin
      value       <= err ? RANGE_W'(draw) : rem + lo;
      range_error <= err;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lcg_ranged_random_top.sv
// a taken request passes the state update, setup and remainder loop states; out_valid
//   rises when the hand-off state loads the result into the output register
// requests are taken one at a time; the remainder loop takes one draw bit per cycle
// the output register lets the next request in while a result waits
// reset: synchronous active-high rst clears the controller, the output valid
//   and the generator state to zero; a seed write reloads the state
`default_nettype none

module lcg_ranged_random_top #(
  parameter int OUT_BITS = 15   // width of the raw draw, 1 to 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // seed register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] seed,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] range_low,
  input  wire logic [15:0] range_high,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      value,
  output logic             range_error
);
  import lcg_rr_pkg::*;

  lcg_rr_cmd_t cmd;
  lcg_rr_sts_t sts;
  logic        cfg_we;

  // seed writes are only taken while idle, so they never race a request
  assign cfg_we = cfg_valid && cfg_ready;

  // sequencer: idle, state update, setup, remainder loop, hand-off
  lcg_rr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // generator state, multiplier, restoring remainder unit, output register
  lcg_rr_dp #(
    .OUT_BITS (OUT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .seed        (seed),
    .range_low   (range_low),
    .range_high  (range_high),
    .value       (value),
    .range_error (range_error)
  );

endmodule

`default_nettype wire

FILE: sv/lcg_rr_chk.sv
`default_nettype none

module lcg_rr_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] value,
  input wire logic        range_error
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(range_error))
    else $error("result changed while stalled");

  // one request in flight: no request taken right after another
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // a seed write never coincides with a request
  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    !(cfg_valid && cfg_ready && in_valid && in_ready))
    else $error("seed write raced a request");

  // a result cannot appear the cycle after a request is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind lcg_ranged_random_top lcg_rr_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .value       (value),
  .range_error (range_error)
);

`default_nettype wire
